// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define CSC_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is held.
`define CSC_ASSERT_NXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define CSC_ASSERT_NXT_ALL(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== sv/csc_pkg.sv =====
`default_nettype none
package csc_pkg;

    localparam int NUM_CELLS = 64;
    localparam int SAMP_W    = 16;
    localparam int PROD_W    = 33;
    localparam int PSUM_W    = 39;
    localparam int SHIFT_Q   = 15;
    localparam int ABS_W     = PSUM_W - SHIFT_Q;
    localparam int SQ_W      = 2 * ABS_W;
    localparam int RAD_W     = 50;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int MAG_W     = 22;
    localparam int CFG_W     = 7;
    localparam int CNT_W     = 7;
    localparam int TAP_IDX_W = 6;
    localparam int SUM_CYCLES = NUM_CELLS + 2;

    localparam logic [ROOT_W-1:0] MAG_MAX = ROOT_W'(4194303);

    localparam logic CFG_WORD_LENGTH  = 1'b0;
    localparam logic CFG_REPEAT_COUNT = 1'b1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TAP    = 1'b1;

    typedef struct packed {
        logic signed [SAMP_W-1:0] im;
        logic signed [SAMP_W-1:0] re;
    } cplx_t;

    typedef struct packed {
        logic signed [PSUM_W-1:0] im;
        logic signed [PSUM_W-1:0] re;
    } psum_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_ABS,
        ST_SQR,
        ST_START,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== sv/csc_cell.sv =====
`default_nettype none
module csc_cell
    import csc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  samp_shift,
    input  wire cplx_t samp_in,
    output cplx_t      samp_out,
    input  wire logic  tap_shift,
    input  wire cplx_t tap_in,
    output cplx_t      tap_out,
    input  wire logic  active,
    input  wire psum_t psum_in,
    output psum_t      psum_out
);

    cplx_t samp_reg;
    cplx_t tap_reg;
    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic signed [PROD_W-1:0] prod_re_next, prod_im_next;
    logic signed [2*SAMP_W-1:0] p_rr, p_ii, p_ir, p_ri;
    psum_t psum_reg;

    assign p_rr = samp_reg.re * tap_reg.re;
    assign p_ii = samp_reg.im * tap_reg.im;
    assign p_ir = samp_reg.im * tap_reg.re;
    assign p_ri = samp_reg.re * tap_reg.im;

    // x * conj(t); cells beyond the active length contribute nothing
    always_comb begin
        prod_re_next = '0;
        prod_im_next = '0;
        if (active) begin
            prod_re_next = PROD_W'(p_rr) + PROD_W'(p_ii);
            prod_im_next = PROD_W'(p_ir) - PROD_W'(p_ri);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samp_reg    <= '0;
            prod_re_reg <= '0;
            prod_im_reg <= '0;
            psum_reg    <= '0;
        end else begin
            if (samp_shift) begin
                samp_reg <= samp_in;
            end
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
            psum_reg.re <= psum_in.re + PSUM_W'(prod_re_reg);
            psum_reg.im <= psum_in.im + PSUM_W'(prod_im_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (tap_shift) begin
            tap_reg <= tap_in;
        end
    end

    assign samp_out = samp_reg;
    assign tap_out  = tap_reg;
    assign psum_out = psum_reg;

endmodule
`default_nettype wire

// ===== sv/csc_isqrt.sv =====
`default_nettype none
module csc_isqrt
    import csc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [RAD_W-1:0] radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    localparam int STEP_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  v_reg, res_reg, bit_reg;
    logic [RAD_W-1:0]  v_next, res_next, bit_next, trial;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next, done_reg, done_next;

    assign trial = res_reg + bit_reg;

    // one result bit per cycle, digit-by-digit
    always_comb begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            v_next    = radicand;
            res_next  = '0;
            bit_next  = RAD_W'(1) << (RAD_W - 2);
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== sv/complex_sync_word_correlator_core.sv =====
// One sample at a time: a sample that completes a window blocks input until its result is
// loaded into the output register, through the tap load sweep, the 64-cell sum chain and
// the bit-serial root, and also while a stalled result holds that register.
// Tap writes and samples that complete no window leave input ready.
// Reset (aresetn low, synchronous): window, tap store, fill count cleared, registers to 1.
`default_nettype none
module complex_sync_word_correlator_core
    import csc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write port
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // [15:0] sample_re, [31:16] sample_im, [37:32] tap_index,
    // [53:38] tap_re, [69:54] tap_im, [71:70] zero
    input  wire logic [71:0]       s_tdata,
    // [0] action
    input  wire logic              s_tuser,
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [21:0] magnitude, [23:22] zero
    output logic [23:0]            m_tdata
);

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    cplx_t                in_samp, in_tap;
    logic [TAP_IDX_W-1:0] in_tap_idx;
    logic                 in_xfer;

    assign in_samp.re = s_tdata[15:0];
    assign in_samp.im = s_tdata[31:16];
    assign in_tap_idx = s_tdata[37:32];
    assign in_tap.re  = s_tdata[53:38];
    assign in_tap.im  = s_tdata[69:54];
    assign in_xfer    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] wl_cfg_reg, rc_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_cfg_reg <= CFG_W'(1);
            rc_cfg_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WORD_LENGTH:  wl_cfg_reg <= cfg_wdata;
                CFG_REPEAT_COUNT: rc_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective word length and correlation length; zero acts as one,
    // word length clamps at the store depth, the product at the cell count.
    logic [CFG_W-1:0]   wl_eff, rc_eff, len_eff;
    logic [2*CFG_W-1:0] len_full;

    always_comb begin
        wl_eff = wl_cfg_reg;
        if (wl_cfg_reg == '0) begin
            wl_eff = CFG_W'(1);
        end else if (wl_cfg_reg > CFG_W'(NUM_CELLS)) begin
            wl_eff = CFG_W'(NUM_CELLS);
        end
        rc_eff   = (rc_cfg_reg == '0) ? CFG_W'(1) : rc_cfg_reg;
        len_full = wl_eff * rc_eff;
        len_eff  = (len_full > (2*CFG_W)'(NUM_CELLS)) ? CFG_W'(NUM_CELLS)
                                                      : len_full[CFG_W-1:0];
    end

    // ------------------------------------------------------------------
    // Tap store: one write port, one registered read port; valid bits
    // make untouched entries read as zero after reset.
    // ------------------------------------------------------------------
    cplx_t                 tap_mem [NUM_CELLS];
    logic [NUM_CELLS-1:0]  tap_valid_reg;
    logic                  tap_wr;
    logic                  rd_en;
    logic [TAP_IDX_W-1:0]  pos_reg, pos_next;
    cplx_t                 rd_data_reg;
    logic                  rd_hit_reg, rd_en_reg;
    cplx_t                 tap_feed;

    assign tap_wr = in_xfer && (s_tuser == ACT_TAP);

    always_ff @(posedge aclk) begin
        if (tap_wr) begin
            tap_mem[in_tap_idx] <= in_tap;
        end
        rd_data_reg <= tap_mem[pos_reg];
        rd_hit_reg  <= tap_valid_reg[pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_valid_reg <= '0;
            rd_en_reg     <= 1'b0;
        end else begin
            if (tap_wr) begin
                tap_valid_reg[in_tap_idx] <= 1'b1;
            end
            rd_en_reg <= rd_en;
        end
    end

    assign tap_feed = rd_hit_reg ? rd_data_reg : '0;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] len_reg, len_next, wl_reg, wl_next;
    logic [CNT_W-1:0] fill_reg, fill_next, fill_inc;
    logic             samp_shift;
    logic             root_start;
    logic             root_done;
    logic             out_load;
    logic [CFG_W-1:0] pos_plus;

    assign fill_inc = (fill_reg == CNT_W'(NUM_CELLS)) ? fill_reg : fill_reg + CNT_W'(1);
    assign pos_plus = CFG_W'(pos_reg) + CFG_W'(1);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        wl_next    = wl_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        s_tready   = 1'b0;
        samp_shift = 1'b0;
        rd_en      = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_xfer && (s_tuser == ACT_SAMPLE)) begin
                    samp_shift = 1'b1;
                    fill_next  = fill_inc;
                    // hold until the window covers the whole length
                    if (fill_inc >= len_eff) begin
                        len_next   = len_eff;
                        wl_next    = wl_eff;
                        cnt_next   = '0;
                        pos_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                // read taps oldest-first; each passes through the read data register into the chain
                rd_en    = (cnt_reg < len_reg);
                cnt_next = cnt_reg + CNT_W'(1);
                if (rd_en) begin
                    pos_next = (pos_plus == wl_reg) ? '0 : pos_plus[TAP_IDX_W-1:0];
                end
                if (cnt_reg == len_reg) begin
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                // let products settle and the partial sums run the chain
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_CYCLES - 1)) begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:   state_next = ST_SQR;
            ST_SQR:   state_next = ST_START;
            ST_START: begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // drop into the output register once it is free
                if (!m_tvalid || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            pos_reg   <= '0;
            len_reg   <= CFG_W'(1);
            wl_reg    <= CFG_W'(1);
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            wl_reg    <= wl_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: window samples and taps advance one cell per cycle while their
    // shift enable is high, partial sums every cycle; cell 0 holds the newest sample.
    // ------------------------------------------------------------------
    cplx_t samp_link [NUM_CELLS+1];
    cplx_t tap_link  [NUM_CELLS+1];
    psum_t psum_link [NUM_CELLS+1];

    assign samp_link[0] = in_samp;
    assign tap_link[0]  = tap_feed;
    assign psum_link[0] = '0;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        csc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .samp_shift (samp_shift),
            .samp_in    (samp_link[i]),
            .samp_out   (samp_link[i+1]),
            .tap_shift  (rd_en_reg),
            .tap_in     (tap_link[i]),
            .tap_out    (tap_link[i+1]),
            .active     (len_reg > CFG_W'(i)),
            .psum_in    (psum_link[i]),
            .psum_out   (psum_link[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale, square and root
    // ------------------------------------------------------------------
    logic signed [ABS_W-1:0] sc_re, sc_im;
    logic [ABS_W-1:0]        ar_reg, am_reg;
    logic [SQ_W-1:0]         sq_re_reg, sq_im_reg;
    logic [RAD_W-1:0]        radicand;
    logic [ROOT_W-1:0]       root;

    // arithmetic shift right floors
    assign sc_re = psum_link[NUM_CELLS].re[PSUM_W-1:SHIFT_Q];
    assign sc_im = psum_link[NUM_CELLS].im[PSUM_W-1:SHIFT_Q];

    always_ff @(posedge aclk) begin
        ar_reg    <= sc_re[ABS_W-1] ? ABS_W'(-sc_re) : ABS_W'(sc_re);
        am_reg    <= sc_im[ABS_W-1] ? ABS_W'(-sc_im) : ABS_W'(sc_im);
        sq_re_reg <= ar_reg * ar_reg;
        sq_im_reg <= am_reg * am_reg;
    end

    assign radicand = RAD_W'(sq_re_reg) + RAD_W'(sq_im_reg);

    csc_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    // ------------------------------------------------------------------
    // Output register: saturate and hold until the transfer completes
    // ------------------------------------------------------------------
    logic             m_valid_reg;
    logic [MAG_W-1:0] m_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_mag_reg <= (root > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : root[MAG_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_mag_reg};

endmodule
`default_nettype wire

// ===== sv/csc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module csc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // a stalled result stays offered
    `CSC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // no result can appear the cycle after any input transfer
    `CSC_ASSERT_NXT(a_no_instant, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid))

    // input is refused while a new result is being raised
    `CSC_ASSERT_IMP(a_busy_rise, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))

    // reset empties the output
    `CSC_ASSERT_NXT_ALL(a_reset_out, aclk, !aresetn, !m_tvalid)

endmodule

bind complex_sync_word_correlator_core csc_checker u_csc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire
